>>> src/gray_histogram_frequency_top_defines.svh
// Assertion macros shared by the gray histogram RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef GRAY_HISTOGRAM_FREQUENCY_TOP_DEFINES_SVH
`define GRAY_HISTOGRAM_FREQUENCY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ghf_pkg.sv
// Shared constants and types for the gray histogram block.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps

package ghf_pkg;

    // Default sizes
    localparam int BINS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 20;

    // Operation codes carried in func
    localparam logic [1:0] FN_ADD   = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // Frequency format: unsigned Q0.16 plus one integer bit for 1.0
    localparam int FRAC_W = 16;
    localparam int FREQ_W = FRAC_W + 1;
    localparam logic [FREQ_W-1:0] Q_ONE = FREQ_W'(65536);

    // Divider handshake
    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_div_sts;

endpackage

>>> src/ghf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; used for the histogram bin store.
`timescale 1ns / 1ps

module ghf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read old contents on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ghf_div.sv
// Radix-2 restoring divider producing the rounded Q0.16 bin frequency.
// Depends on ghf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gray_histogram_frequency_top_defines.svh"

module ghf_div #(
    parameter int COUNT_BITS = ghf_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ghf_pkg::t_div_ctl             i_ctl,
    output ghf_pkg::t_div_sts             o_sts,
    input  logic [COUNT_BITS-1:0]         i_cnt,
    input  logic [COUNT_BITS-1:0]         i_total,
    output logic [COUNT_BITS-1:0]         o_cnt,
    output logic [COUNT_BITS-1:0]         o_total,
    output logic [ghf_pkg::FREQ_W-1:0]    o_freq
);
    import ghf_pkg::*;

    localparam int NUM_W  = COUNT_BITS + FREQ_W;
    localparam int STEP_W = $clog2(FREQ_W);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_DONE = 3'b100
    } t_dv_state;

    t_dv_state               r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [COUNT_BITS-1:0]   r_rem, n_rem;
    logic [FREQ_W-1:0]       r_nlo, n_nlo;
    logic [FREQ_W-1:0]       r_q, n_q;
    logic [COUNT_BITS-1:0]   r_den, n_den;
    logic [COUNT_BITS-1:0]   r_cnt, n_cnt;
    logic                    r_zero, n_zero;

    logic [NUM_W-1:0]        w_num;
    logic [COUNT_BITS:0]     w_trial;
    logic [COUNT_BITS:0]     w_diff;
    logic                    w_ge;

    // Dividend with half the divisor added for round-half-up
    assign w_num = {1'b0, i_cnt, FRAC_W'(0)} + NUM_W'(i_total >> 1);

    // One quotient bit per cycle
    assign w_trial = {r_rem, r_nlo[FREQ_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_nlo   = r_nlo;
        n_q     = r_q;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_zero  = r_zero;
        unique case (r_state)
            DV_IDLE: begin
                if (i_ctl.start) begin
                    n_state = DV_RUN;
                    n_step  = STEP_W'(FREQ_W - 1);
                    n_rem   = w_num[NUM_W-1:FREQ_W];
                    n_nlo   = w_num[FREQ_W-1:0];
                    n_q     = '0;
                    n_den   = i_total;
                    n_cnt   = i_cnt;
                    n_zero  = (i_total == '0);
                end
            end
            DV_RUN: begin
                n_rem  = w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
                n_nlo  = {r_nlo[FREQ_W-2:0], 1'b0};
                n_q    = {r_q[FREQ_W-2:0], w_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                if (i_ctl.take) begin
                    n_state = DV_IDLE;
                end
            end
            default: n_state = DV_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_rem  <= n_rem;
        r_nlo  <= n_nlo;
        r_q    <= n_q;
        r_den  <= n_den;
        r_cnt  <= n_cnt;
        r_zero <= n_zero;
    end

    // Zero for an empty histogram, limit to 1.0
    always_comb begin
        priority if (r_zero) begin
            o_freq = '0;
        end else if (r_q > Q_ONE) begin
            o_freq = Q_ONE;
        end else begin
            o_freq = r_q;
        end
    end

    assign o_sts.idle = (r_state == DV_IDLE);
    assign o_sts.done = (r_state == DV_DONE);
    assign o_cnt      = r_cnt;
    assign o_total    = r_den;

    `GHF_ASSERT_SAME(a_start_when_idle, i_ctl.start, r_state == DV_IDLE, "divider started while busy")
    `GHF_ASSERT_SAME(a_take_when_done, i_ctl.take, r_state == DV_DONE, "result taken before done")
    `GHF_ASSERT_NEXT(a_last_step, (r_state == DV_RUN) && (r_step == '0), r_state == DV_DONE, "divider overran its step count")
    `GHF_ASSERT_SAME(a_freq_limit, r_state == DV_DONE, o_freq <= Q_ONE, "frequency above one")

endmodule

>>> src/gray_histogram_frequency_top.sv
// Gray histogram with normalized readout. An add beat counts one pixel and is taken every
// clock when not stalled, back to back, including repeats of the same gray level; the bin
// store is a RAM with a registered read, updated by read-modify-write with the previous
// write forwarded. A read beat snapshots the bin count and pixel total and hands them to a
// restoring divider that produces one quotient bit per cycle; adds keep flowing meanwhile,
// and a second read waits for the divider, holding off all beats while it waits. A clear
// beat, and reset, run a clearing pass over the RAM, one entry per cycle, during which no
// beat is taken.
// Depends on ghf_pkg, ghf_ram, ghf_div and the assertion macro header.
`timescale 1ns / 1ps
`include "gray_histogram_frequency_top_defines.svh"

module gray_histogram_frequency_top #(
    parameter int BINS       = ghf_pkg::BINS_DEF,
    parameter int COUNT_BITS = ghf_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_func,
    input  logic [7:0]                 i_pixel_value,
    input  logic [7:0]                 i_bin_index,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [COUNT_BITS-1:0]      o_bin_count,
    output logic [ghf_pkg::FREQ_W-1:0] o_frequency,
    output logic [COUNT_BITS-1:0]      o_pixel_total
);
    import ghf_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_sweep_addr, n_sweep_addr;
    logic [COUNT_BITS-1:0] r_total, n_total;

    logic                  r_s1_valid;
    logic [1:0]            r_s1_func;
    logic [IDX_W-1:0]      r_s1_addr;
    logic                  r_s1_inrange;

    logic                  r_fwd_valid;
    logic [IDX_W-1:0]      r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    logic                  r_pend_valid, n_pend_valid;
    logic [COUNT_BITS-1:0] r_pend_cnt;
    logic [COUNT_BITS-1:0] r_pend_total;

    logic                  r_out_valid, n_out_valid;
    logic [COUNT_BITS-1:0] r_out_cnt;
    logic [FREQ_W-1:0]     r_out_freq;
    logic [COUNT_BITS-1:0] r_out_total;

    logic                  w_accept;
    logic [IDX_W-1:0]      w_raddr;
    logic                  w_inrange;
    logic [COUNT_BITS-1:0] w_rdata;
    logic [COUNT_BITS-1:0] w_cnt_cur;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic                  w_s1_add;
    logic                  w_s1_read;
    logic                  w_s1_clear;
    logic                  w_sweep;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;

    t_div_ctl              div_ctl;
    t_div_sts              div_sts;
    logic [COUNT_BITS-1:0] w_div_cnt_in;
    logic [COUNT_BITS-1:0] w_div_total_in;
    logic [COUNT_BITS-1:0] w_div_cnt;
    logic [COUNT_BITS-1:0] w_div_total;
    logic [FREQ_W-1:0]     w_div_freq;

    // Decode the incoming beat and address the RAM with it
    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_raddr   = (i_func == FN_READ) ? IDX_W'(i_bin_index) : IDX_W'(i_pixel_value);
    assign w_inrange = (i_func == FN_READ) ? (32'(i_bin_index) < BINS)
                                           : (32'(i_pixel_value) < BINS);

    // Stage one: pick up the read data, forward the write of the last cycle
    assign w_s1_add   = r_s1_valid && (r_s1_func == FN_ADD) && r_s1_inrange;
    assign w_s1_read  = r_s1_valid && (r_s1_func == FN_READ);
    assign w_s1_clear = r_s1_valid && (r_s1_func == FN_CLEAR);
    assign w_cnt_cur  = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : w_rdata;
    assign w_cnt_inc  = (w_cnt_cur == COUNT_MAX) ? w_cnt_cur : w_cnt_cur + 1'b1;
    assign w_rd_cnt   = r_s1_inrange ? w_cnt_cur : '0;
    assign w_sweep    = (r_state == ST_SWEEP);

    // Hold off beats during a clear and while a read waits for the divider
    assign o_in_stall = w_sweep || w_s1_clear || r_pend_valid || (w_s1_read && !div_sts.idle);

    // Share the write port between the clearing pass and the bin update
    assign w_we    = w_sweep || w_s1_add;
    assign w_waddr = w_sweep ? r_sweep_addr : r_s1_addr;
    assign w_wdata = w_sweep ? '0 : w_cnt_inc;

    ghf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Clear sequencing and the running total
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_total      = r_total;
        unique case (r_state)
            ST_RUN: begin
                if (w_s1_clear) begin
                    n_state      = ST_SWEEP;
                    n_sweep_addr = '0;
                    n_total      = '0;
                end else if (w_s1_add && (r_total != COUNT_MAX)) begin
                    n_total = r_total + 1'b1;
                end
            end
            ST_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == IDX_W'(BINS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Start the divider from the waiting read first, else straight from stage one
    assign div_ctl.start  = div_sts.idle && (r_pend_valid || w_s1_read);
    assign div_ctl.take   = div_sts.done && (!r_out_valid || !i_out_stall);
    assign w_div_cnt_in   = r_pend_valid ? r_pend_cnt : w_rd_cnt;
    assign w_div_total_in = r_pend_valid ? r_pend_total : r_total;

    always_comb begin
        n_pend_valid = r_pend_valid;
        if (div_ctl.start && r_pend_valid) begin
            n_pend_valid = 1'b0;
        end else if (w_s1_read && !div_sts.idle) begin
            n_pend_valid = 1'b1;
        end
    end

    ghf_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts),
        .i_cnt   (w_div_cnt_in),
        .i_total (w_div_total_in),
        .o_cnt   (w_div_cnt),
        .o_total (w_div_total),
        .o_freq  (w_div_freq)
    );

    // Output register: load a finished result, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (div_ctl.take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_total      <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_total      <= n_total;
            r_s1_valid   <= w_accept;
            r_fwd_valid  <= w_s1_add;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_func    <= i_func;
            r_s1_addr    <= w_raddr;
            r_s1_inrange <= w_inrange;
        end
        if (w_s1_add) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= w_cnt_inc;
        end
        if (w_s1_read && !div_sts.idle) begin
            r_pend_cnt   <= w_rd_cnt;
            r_pend_total <= r_total;
        end
        if (div_ctl.take) begin
            r_out_cnt   <= w_div_cnt;
            r_out_freq  <= w_div_freq;
            r_out_total <= w_div_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bin_count   = r_out_cnt;
    assign o_frequency   = r_out_freq;
    assign o_pixel_total = r_out_total;

    `GHF_ASSERT_SAME(a_sweep_owns_port, w_sweep, !r_s1_valid, "bin update during clearing pass")
    `GHF_ASSERT_SAME(a_pend_needs_busy, r_pend_valid, !div_sts.idle || div_ctl.start, "read parked with divider free")
    `GHF_ASSERT_SAME(a_fwd_in_run, r_fwd_valid, r_state == ST_RUN, "forwarded write survived a clear")
    `GHF_ASSERT_SAME(a_bin_le_total, o_out_valid, o_bin_count <= o_pixel_total, "bin count above pixel total")

endmodule

>>> test/tb.sv
// Self-checking testbench for gray_histogram_frequency_top: directed beats, a back-to-back
// burst and random pixel streams, checked against an in-bench histogram predictor.
// Depends on ghf_pkg and the gray_histogram_frequency_top RTL.
`timescale 1ns / 1ps

module tb;
    import ghf_pkg::*;

    localparam int CNT_W = COUNT_BITS_DEF;
    localparam int NBINS = BINS_DEF;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    // Operation code the block ignores
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1600;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel;
        logic [7:0] bin;
    } t_pixel_op;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [FREQ_W-1:0] freq;
        logic [CNT_W-1:0]  total;
    } t_bin_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_func = FN_ADD;
    logic [7:0]        i_pixel_value = '0;
    logic [7:0]        i_bin_index = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CNT_W-1:0]  o_bin_count;
    logic [FREQ_W-1:0] o_frequency;
    logic [CNT_W-1:0]  o_pixel_total;

    // Histogram predictor state
    logic [CNT_W-1:0] bin_model [NBINS] = '{default: '0};
    logic [CNT_W-1:0] total_model = '0;

    t_pixel_op   pending_ops[$];
    t_bin_report expected_reads[$];
    t_pixel_op   drive_op;
    bit          in_taken = 1'b0;
    bit          steady = 1'b0;
    int          beats_pushed = 0;
    int          beats_taken = 0;
    int          fail_count = 0;

    gray_histogram_frequency_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pixel_value (i_pixel_value),
        .i_bin_index   (i_bin_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bin_count   (o_bin_count),
        .o_frequency   (o_frequency),
        .o_pixel_total (o_pixel_total)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Count over total in Q0.16, ties rounded up, capped at one
    function automatic logic [FREQ_W-1:0] q16_share(input logic [CNT_W-1:0] count,
                                                   input logic [CNT_W-1:0] total);
        logic [63:0] quot;
        if (total == '0) return '0;
        quot = ((64'(count) << FRAC_W) + 64'(total >> 1)) / 64'(total);
        return (quot > 64'(Q_ONE)) ? Q_ONE : quot[FREQ_W-1:0];
    endfunction

    // Apply one beat to the model histogram and queue the read result it causes
    function automatic void histogram_step(input t_pixel_op op);
        t_bin_report rep;
        case (op.func)
            FN_ADD: begin
                if (bin_model[op.pixel] != COUNT_MAX) bin_model[op.pixel]++;
                if (total_model != COUNT_MAX) total_model++;
            end
            FN_READ: begin
                rep.count = bin_model[op.bin];
                rep.freq  = q16_share(bin_model[op.bin], total_model);
                rep.total = total_model;
                expected_reads.insert(expected_reads.size(), rep);
            end
            FN_CLEAR: begin
                foreach (bin_model[k]) bin_model[k] = '0;
                total_model = '0;
            end
            default: ;
        endcase
    endfunction

    // Drive the next beat once the current one is taken; idle and stall at random unless steady
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                drive_op = pending_ops.pop_front();
                i_in_valid    <= 1'b1;
                i_func        <= drive_op.func;
                i_pixel_value <= drive_op.pixel;
                i_bin_index   <= drive_op.bin;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !steady && ($urandom_range(99) < 20);
    end

    // Record accepted input beats and check accepted results
    always @(posedge i_clk) begin
        t_bin_report want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            histogram_step('{func: i_func, pixel: i_pixel_value, bin: i_bin_index});
            beats_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reads.size() == 0) begin
                $error("result beat with no read pending");
                fail_count++;
            end else begin
                want = expected_reads.pop_front();
                if (o_bin_count !== want.count) begin
                    $error("bin_count: expected %0d, got %0d", want.count, o_bin_count);
                    fail_count++;
                end
                if (o_frequency !== want.freq) begin
                    $error("frequency: expected %0d, got %0d", want.freq, o_frequency);
                    fail_count++;
                end
                if (o_pixel_total !== want.total) begin
                    $error("pixel_total: expected %0d, got %0d", want.total, o_pixel_total);
                    fail_count++;
                end
            end
        end
    end

    // Queue one beat; hold while the driver has plenty buffered
    task automatic push_op(input logic [1:0] fn, input logic [7:0] pix, input logic [7:0] idx);
        t_pixel_op op;
        op.func  = fn;
        op.pixel = pix;
        op.bin   = idx;
        pending_ops.insert(pending_ops.size(), op);
        beats_pushed++;
        while (pending_ops.size() > 32) @(negedge i_clk);
    endtask

    task automatic push_add(input logic [7:0] pix);
        push_op(FN_ADD, pix, 8'($urandom_range(255)));
    endtask

    task automatic push_read(input logic [7:0] idx);
        push_op(FN_READ, 8'($urandom_range(255)), idx);
    endtask

    // Hold until every beat is taken and every read has returned
    task automatic drain();
        while (beats_taken != beats_pushed || expected_reads.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] lvl_a, lvl_b, lvl_c;
        logic [7:0] hot [4];
        int counted;
        int n_hot;
        int seg_len;
        int pick;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty histogram, extremes, unused code, clear
        push_read(8'd0);
        push_add(8'd0);
        push_add(8'd255);
        push_add(8'd255);
        push_read(8'd0);
        push_read(8'd255);
        push_read(8'd128);
        push_op(FN_UNUSED, 8'd255, 8'd255);
        push_op(FN_UNUSED, 8'd0, 8'd0);
        push_read(8'd255);
        push_op(FN_CLEAR, 8'd255, 8'd255);
        push_read(8'd255);
        push_add(8'd7);
        push_read(8'd7);
        push_add(8'd128);
        push_add(8'd128);
        push_add(8'd127);
        push_read(8'd128);
        push_read(8'd127);
        push_op(FN_READ, 8'd0, 8'd255);
        push_op(FN_ADD, 8'd1, 8'd0);
        push_read(8'd1);
        push_op(FN_CLEAR, 8'd0, 8'd0);
        push_read(8'd7);
        drain();

        // Back-to-back burst with no idling: one gray level repeated, then reads
        steady = 1'b1;
        lvl_a = 8'($urandom_range(255));
        lvl_b = lvl_a + 8'($urandom_range(100)) + 8'd1;
        lvl_c = lvl_b + 8'($urandom_range(100)) + 8'd1;
        push_op(FN_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
        push_add(lvl_b);
        repeat (100) push_add(lvl_a);
        push_read(lvl_b);
        push_read(lvl_a);
        repeat (20) push_add(lvl_a);
        push_read(lvl_a);
        push_read(lvl_b);
        repeat (5) push_add(lvl_c);
        push_read(lvl_c);
        push_read(8'($urandom_range(255)));
        push_op(FN_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
        push_read(lvl_a);
        drain();
        steady = 1'b0;

        // Random pixel streams over a few hot gray levels, with reads, clears and noise
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            steady = (counted >= 800 && counted < 1000);
            if ($urandom_range(99) < 12) begin
                push_op(FN_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
                counted++;
            end
            n_hot = $urandom_range(4, 1);
            foreach (hot[k]) hot[k] = 8'($urandom_range(255));
            seg_len = $urandom_range(40, 4);
            repeat (seg_len) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    if ($urandom_range(99) < 80) push_add(hot[$urandom_range(n_hot - 1)]);
                    else push_add(8'($urandom_range(255)));
                    counted++;
                end else if (pick < 90) begin
                    if ($urandom_range(99) < 70) push_read(hot[$urandom_range(n_hot - 1)]);
                    else push_read(8'($urandom_range(255)));
                    counted++;
                end else if (pick < 95) begin
                    push_op(FN_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
                end else begin
                    push_add(8'($urandom_range(255)));
                    counted++;
                end
            end
        end
        steady = 1'b0;

        // Wait out the last results and any clearing pass still running
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_reads.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
